/* design/sbm_pkg.sv */
package sbm_pkg;

	localparam int unsigned REG_W      = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned DIV_STEPS  = 4;
	localparam int unsigned DIV_CNT_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_VARIANT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REVISION_1A     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE_UNITS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_32K_BOARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM_OVER_8K = 3'd4;

	// board variants
	localparam logic [2:0] VAR_STANDARD  = 3'd0;
	localparam logic [2:0] VAR_EXT_RAM   = 3'd1;
	localparam logic [2:0] VAR_RAM_EN    = 3'd2;
	localparam logic [2:0] VAR_RAM_BIT3  = 3'd3;
	localparam logic [2:0] VAR_OUTER_PRG = 3'd4;
	localparam logic [2:0] VAR_RAM_BIT4  = 3'd5;

	// serial load targets, by address bits 14:13
	localparam logic [1:0] TGT_CONTROL = 2'd0;
	localparam logic [1:0] TGT_CHR_A   = 2'd1;
	localparam logic [1:0] TGT_CHR_B   = 2'd2;
	localparam logic [1:0] TGT_PRG     = 2'd3;

	// PRG modes from control bits 3:2
	localparam logic [1:0] PRG_FIX_FIRST = 2'b10;
	localparam logic [1:0] PRG_FIX_LAST  = 2'b11;

	localparam logic [REG_W-1:0] CONTROL_RESET = 5'h0C;
	localparam logic [REG_W-1:0] PRG_MODE_BITS = 5'h0C;
	localparam logic [5:0]       SIZE_RESET    = 6'd16;
	localparam logic [5:0]       SIZE_SMALL    = 6'd2;
	localparam logic [5:0]       SIZE_OUTER    = 6'd16;
	localparam logic [2:0]       LAST_BIT_CNT  = 3'd4;

	typedef struct packed {
		logic accept;
		logic step;
		logic out_load;
	} sbm_cmd_t;

	typedef struct packed {
		logic div_last;
	} sbm_status_t;

endpackage

/* design/sbm_ctrl.sv */
module sbm_ctrl
	import sbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  sbm_status_t status,
	output sbm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CALC   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.step     = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/sbm_dpath.sv */
module sbm_dpath
	import sbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbm_cmd_t              cmd,
	output sbm_status_t           status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  kind,
	input  logic [7:0]            write_data,
	input  logic [1:0]            address_high,
	input  logic                  back_to_back,
	input  logic                  upper_pattern_table,
	output logic [4:0]            prg_bank_low_window,
	output logic [4:0]            prg_bank_high_window,
	output logic [4:0]            chr_bank_lower,
	output logic [4:0]            chr_bank_upper,
	output logic [1:0]            mirroring,
	output logic                  ram_enabled,
	output logic [1:0]            ram_bank
);

	logic [2:0] variant_cfg_q;
	logic       rev1a_q;
	logic [5:0] size_q;
	logic       fixed32_q;
	logic       over8k_q;

	logic [REG_W-1:0] ctrl_q, chr_a_q, chr_b_q, prg_q, shift_q;
	logic [2:0]       cnt_q;
	logic             phase_q;

	logic [REG_W-1:0] ctrl_d, chr_a_d, chr_b_d, prg_d, shift_d;
	logic [2:0]       cnt_d;
	logic             phase_d;
	logic [REG_W-1:0] shift_new;

	// restoring divider for the PRG bank modulo
	logic [3:0]           num_q;
	logic [5:0]           rem_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [6:0]           trial;

	logic [4:0] plo_q, phi_q, clo_q, chi_q;
	logic [1:0] mir_q, rbank_q;
	logic       ren_q;

	logic [2:0] variant;
	logic [4:0] act;
	logic [1:0] mode;
	logic [4:0] base, obank, bank, first, last, mask, cb;
	logic [5:0] size_m1;
	logic [4:0] plo, phi, clo, chi;
	logic       ren;
	logic [1:0] rbank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_cfg_q <= VAR_STANDARD;
			rev1a_q       <= 1'b0;
			size_q        <= SIZE_RESET;
			fixed32_q     <= 1'b0;
			over8k_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOARD_VARIANT:   variant_cfg_q <= cfg_data[2:0];
				CFG_REVISION_1A:     rev1a_q       <= cfg_data[0];
				CFG_PRG_SIZE_UNITS:  size_q        <= cfg_data;
				CFG_FIXED_32K_BOARD: fixed32_q     <= cfg_data[0];
				CFG_PRG_RAM_OVER_8K: over8k_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign shift_new = {write_data[0], shift_q[REG_W-1:1]};

	always_comb begin
		ctrl_d  = ctrl_q;
		chr_a_d = chr_a_q;
		chr_b_d = chr_b_q;
		prg_d   = prg_q;
		shift_d = shift_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		if (kind) begin
			phase_d = upper_pattern_table;
		end else if (write_data[7]) begin
			shift_d = '0;
			cnt_d   = '0;
			ctrl_d  = ctrl_q | PRG_MODE_BITS;
		end else if (!back_to_back) begin
			shift_d = shift_new;
			cnt_d   = cnt_q + 3'd1;
			if (cnt_q >= LAST_BIT_CNT) begin
				case (address_high)
					TGT_CONTROL: ctrl_d  = shift_new;
					TGT_CHR_A:   chr_a_d = shift_new;
					TGT_CHR_B:   chr_b_d = shift_new;
					TGT_PRG:     prg_d   = shift_new;
					default:     prg_d   = shift_new;
				endcase
				shift_d = '0;
				cnt_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= CONTROL_RESET;
			chr_a_q <= '0;
			chr_b_q <= '0;
			prg_q   <= '0;
			shift_q <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
			step_q  <= '0;
		end else if (cmd.accept) begin
			ctrl_q  <= ctrl_d;
			chr_a_q <= chr_a_d;
			chr_b_q <= chr_b_d;
			prg_q   <= prg_d;
			shift_q <= shift_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			step_q  <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + 1'b1;
		end
	end

	assign trial           = {rem_q, num_q[3]};
	assign status.div_last = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_q <= prg_d[3:0];
			rem_q <= '0;
		end else if (cmd.step) begin
			num_q <= {num_q[2:0], 1'b0};
			if (trial >= {1'b0, size_q}) begin
				rem_q <= 6'(trial - {1'b0, size_q});
			end else begin
				rem_q <= trial[5:0];
			end
		end
	end

	always_comb begin
		variant = (variant_cfg_q > VAR_RAM_BIT4) ? VAR_STANDARD : variant_cfg_q;
		act     = (ctrl_q[4] && phase_q) ? chr_b_q : chr_a_q;
		mode    = ctrl_q[3:2];

		base    = {(size_q > SIZE_OUTER) && act[4], 4'b0000};
		obank   = base | {1'b0, prg_q[3:0]};
		bank    = rem_q[4:0];
		size_m1 = size_q - 6'd1;
		first   = '0;
		last    = size_m1[4:0];
		if (rev1a_q && prg_q[4]) begin
			first = {1'b0, prg_q[3], 3'b000};
			last  = first | 5'h07;
		end

		if (size_q <= SIZE_SMALL || fixed32_q) begin
			plo = 5'd0;
			phi = 5'd1;
		end else if (variant == VAR_EXT_RAM || variant == VAR_OUTER_PRG) begin
			case (mode)
				PRG_FIX_FIRST: begin
					plo = base;
					phi = obank;
				end
				PRG_FIX_LAST: begin
					plo = obank;
					phi = base | 5'h0F;
				end
				default: begin
					plo = obank & 5'h1E;
					phi = obank | 5'h01;
				end
			endcase
		end else begin
			case (mode)
				PRG_FIX_FIRST: begin
					plo = first;
					phi = bank;
				end
				PRG_FIX_LAST: begin
					plo = bank;
					phi = last;
				end
				default: begin
					plo = bank & 5'h1E;
					phi = bank | 5'h01;
				end
			endcase
		end

		if (variant == VAR_STANDARD) begin
			mask = 5'h1F;
		end else if (variant == VAR_RAM_BIT4) begin
			mask = 5'h0F;
		end else begin
			mask = 5'h01;
		end
		cb = chr_a_q & mask & 5'h1E;
		if (ctrl_q[4]) begin
			clo = chr_a_q & mask;
			chi = chr_b_q & mask;
		end else begin
			clo = cb;
			chi = cb | 5'h01;
		end

		ren = rev1a_q ? 1'b1 : !prg_q[4];
		if (variant == VAR_RAM_EN && act[4]) begin
			ren = 1'b0;
		end

		case (variant)
			VAR_EXT_RAM:  rbank = over8k_q ? act[3:2] : 2'd0;
			VAR_RAM_BIT3: rbank = {1'b0, act[3]};
			VAR_RAM_BIT4: rbank = {1'b0, act[4]};
			default:      rbank = 2'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			plo_q   <= plo;
			phi_q   <= phi;
			clo_q   <= clo;
			chi_q   <= chi;
			mir_q   <= ctrl_q[1:0];
			ren_q   <= ren;
			rbank_q <= rbank;
		end
	end

	assign prg_bank_low_window  = plo_q;
	assign prg_bank_high_window = phi_q;
	assign chr_bank_lower       = clo_q;
	assign chr_bank_upper       = chi_q;
	assign mirroring            = mir_q;
	assign ram_enabled          = ren_q;
	assign ram_bank             = rbank_q;

endmodule

/* design/serial_loaded_bank_mapper.sv */
// Serial-loaded bank mapper. Each input item is a CPU write (kind 0) that feeds the
// five-bit serial port, or a pattern-table phase update (kind 1); every item yields one
// result with the current PRG, CHR, mirroring and PRG-RAM mapping. The mapper registers
// update at the input transfer; the result then goes through four steps of a restoring
// divider that reduces the PRG bank modulo the ROM size and a final step that loads the
// output register. A new item is taken only once the block returns to idle after the
// load, so none is taken while one is still being computed; the output register lets
// the next item start while a result still waits, and the block holds in its final step
// if that result is not taken. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so only while no item is in flight; the block does not enforce it.
module serial_loaded_bank_mapper
	import sbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [7:0]            write_data,
	input  logic [1:0]            address_high,
	input  logic                  back_to_back,
	input  logic                  upper_pattern_table,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [4:0]            prg_bank_low_window,
	output logic [4:0]            prg_bank_high_window,
	output logic [4:0]            chr_bank_lower,
	output logic [4:0]            chr_bank_upper,
	output logic [1:0]            mirroring,
	output logic                  ram_enabled,
	output logic [1:0]            ram_bank
);

	sbm_cmd_t    cmd;
	sbm_status_t status;

	sbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sbm_dpath u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.kind                 (kind),
		.write_data           (write_data),
		.address_high         (address_high),
		.back_to_back         (back_to_back),
		.upper_pattern_table  (upper_pattern_table),
		.prg_bank_low_window  (prg_bank_low_window),
		.prg_bank_high_window (prg_bank_high_window),
		.chr_bank_lower       (chr_bank_lower),
		.chr_bank_upper       (chr_bank_upper),
		.mirroring            (mirroring),
		.ram_enabled          (ram_enabled),
		.ram_bank             (ram_bank)
	);

endmodule

/* test/tb_serial_loaded_bank_mapper.sv */
module tb_serial_loaded_bank_mapper;
	timeunit 1ns;
	timeprecision 1ps;

	import sbm_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;

	// indexes past the end of the register list
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] addr;
		logic       b2b;
		logic       a12;
	} bus_item_t;

	typedef struct packed {
		logic [4:0] prg_lo;
		logic [4:0] prg_hi;
		logic [4:0] chr_lo;
		logic [4:0] chr_hi;
		logic [1:0] mirror;
		logic       ram_on;
		logic [1:0] ram_sel;
	} mapping_t;

	logic                  clk;
	logic                  arst_n              = 1'b0;
	logic                  cfg_we              = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index           = '0;
	logic [CFG_DATA_W-1:0] cfg_data            = '0;
	logic                  in_valid            = 1'b0;
	logic                  in_ready;
	logic                  kind                = 1'b0;
	logic [7:0]            write_data          = '0;
	logic [1:0]            address_high        = '0;
	logic                  back_to_back        = 1'b0;
	logic                  upper_pattern_table = 1'b0;
	logic                  out_valid;
	logic                  out_ready           = 1'b0;
	logic [4:0]            prg_bank_low_window;
	logic [4:0]            prg_bank_high_window;
	logic [4:0]            chr_bank_lower;
	logic [4:0]            chr_bank_upper;
	logic [1:0]            mirroring;
	logic                  ram_enabled;
	logic [1:0]            ram_bank;

	// mapper state as the block should hold it
	logic [REG_W-1:0] ctrl_r, chr_a_r, chr_b_r, prg_r, shift_r;
	logic [2:0]       shift_cnt;
	logic             a12_r;
	logic [2:0]       board_sel;
	logic             old_rev;
	logic [5:0]       rom_units;
	logic             force_32k;
	logic             big_ram;

	mapping_t expected_maps[$];
	int       errors        = 0;
	int       items_sent    = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       idle_cycles   = 0;
	int       hold_left     = 0;
	logic     hold_start    = 1'b0;

	serial_loaded_bank_mapper u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic mapping_t next_mapping(input bus_item_t it);
		logic [2:0] board;
		logic [4:0] act, base, bank, first, last_bank, mask, pair;
		logic [5:0] top, rem;
		logic [1:0] mode;
		mapping_t   m;
		if (it.kind) begin
			a12_r = it.a12;
		end else if (it.data[7]) begin
			shift_r   = '0;
			shift_cnt = '0;
			ctrl_r    = ctrl_r | PRG_MODE_BITS;
		end else if (!it.b2b) begin
			shift_r   = {it.data[0], shift_r[4:1]};
			shift_cnt = shift_cnt + 3'd1;
			if (shift_cnt > LAST_BIT_CNT) begin
				case (it.addr)
					TGT_CONTROL: ctrl_r = shift_r;
					TGT_CHR_A: chr_a_r = shift_r;
					TGT_CHR_B: chr_b_r = shift_r;
					default: prg_r = shift_r;
				endcase
				shift_r   = '0;
				shift_cnt = '0;
			end
		end

		board = (board_sel > VAR_RAM_BIT4) ? VAR_STANDARD : board_sel;
		act   = (ctrl_r[4] && a12_r) ? chr_b_r : chr_a_r;
		mode  = ctrl_r[3:2];

		if (rom_units <= SIZE_SMALL || force_32k) begin
			m.prg_lo = 5'd0;
			m.prg_hi = 5'd1;
		end else if (board == VAR_EXT_RAM || board == VAR_OUTER_PRG) begin
			base = (rom_units > SIZE_OUTER && act[4]) ? 5'h10 : 5'h00;
			bank = base | {1'b0, prg_r[3:0]};
			if (mode == PRG_FIX_FIRST) begin
				m.prg_lo = base;
				m.prg_hi = bank;
			end else if (mode == PRG_FIX_LAST) begin
				m.prg_lo = bank;
				m.prg_hi = base | 5'h0F;
			end else begin
				m.prg_lo = bank & 5'h1E;
				m.prg_hi = bank | 5'h01;
			end
		end else begin
			rem       = {2'b00, prg_r[3:0]} % rom_units;
			bank      = rem[4:0];
			top       = rom_units - 6'd1;
			first     = '0;
			last_bank = top[4:0];
			// older revision: PRG bit 4 bypasses into a fixed 128 KiB half
			if (old_rev && prg_r[4]) begin
				first     = prg_r & 5'h08;
				last_bank = first | 5'h07;
			end
			if (mode == PRG_FIX_FIRST) begin
				m.prg_lo = first;
				m.prg_hi = bank;
			end else if (mode == PRG_FIX_LAST) begin
				m.prg_lo = bank;
				m.prg_hi = last_bank;
			end else begin
				m.prg_lo = bank & 5'h1E;
				m.prg_hi = bank | 5'h01;
			end
		end

		if (board == VAR_STANDARD)
			mask = 5'h1F;
		else if (board == VAR_RAM_BIT4)
			mask = 5'h0F;
		else
			mask = 5'h01;
		if (ctrl_r[4]) begin
			m.chr_lo = chr_a_r & mask;
			m.chr_hi = chr_b_r & mask;
		end else begin
			pair     = chr_a_r & mask & 5'h1E;
			m.chr_lo = pair;
			m.chr_hi = pair | 5'h01;
		end

		m.mirror = ctrl_r[1:0];
		m.ram_on = old_rev ? 1'b1 : ~prg_r[4];
		if (board == VAR_RAM_EN && act[4])
			m.ram_on = 1'b0;
		case (board)
			VAR_EXT_RAM: m.ram_sel = big_ram ? act[3:2] : 2'd0;
			VAR_RAM_BIT3: m.ram_sel = {1'b0, act[3]};
			VAR_RAM_BIT4: m.ram_sel = {1'b0, act[4]};
			default: m.ram_sel = 2'd0;
		endcase
		return m;
	endfunction

	function automatic void check_field(input string name, input logic [4:0] want,
			input logic [4:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		mapping_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_maps.size() == 0) begin
				$display("%0t: result transfer with nothing pending", $time);
				errors++;
			end else begin
				want = expected_maps.pop_front();
				check_field("prg_bank_low_window", want.prg_lo, prg_bank_low_window);
				check_field("prg_bank_high_window", want.prg_hi, prg_bank_high_window);
				check_field("chr_bank_lower", want.chr_lo, chr_bank_lower);
				check_field("chr_bank_upper", want.chr_hi, chr_bank_upper);
				check_field("mirroring", {3'b000, want.mirror}, {3'b000, mirroring});
				check_field("ram_enabled", {4'b0000, want.ram_on}, {4'b0000, ram_enabled});
				check_field("ram_bank", {3'b000, want.ram_sel}, {3'b000, ram_bank});
			end
		end
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_start) begin
			hold_start <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			out_ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bus_item_t make_write(input logic [7:0] data, input logic [1:0] addr,
			input logic b2b);
		bus_item_t it;
		it.kind = 1'b0;
		it.data = data;
		it.addr = addr;
		it.b2b  = b2b;
		it.a12  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic bus_item_t make_phase(input logic a12);
		bus_item_t it;
		it.kind = 1'b1;
		it.data = 8'($urandom_range(0, 255));
		it.addr = 2'($urandom_range(0, 3));
		it.b2b  = 1'($urandom_range(0, 1));
		it.a12  = a12;
		return it;
	endfunction

	task automatic send_item(input bus_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid            <= 1'b1;
		kind                <= it.kind;
		write_data          <= it.data;
		address_high        <= it.addr;
		back_to_back        <= it.b2b;
		upper_pattern_table <= it.a12;
		do @(posedge clk); while (!in_ready);
		expected_maps.push_back(next_mapping(it));
		items_sent++;
	endtask

	// five serial writes, LSB first; the fifth carries the target address
	task automatic load_serial(input logic [1:0] target, input logic [4:0] value,
			input bit mixed);
		logic [5:0] filler;
		logic [1:0] addr;
		for (int i = 0; i < 5; i++) begin
			if (mixed && $urandom_range(0, 9) == 0)
				send_item(make_phase(1'($urandom_range(0, 1))));
			if (mixed && $urandom_range(0, 11) == 0)
				send_item(make_write(8'($urandom_range(0, 127)), 2'($urandom_range(0, 3)), 1'b1));
			filler = 6'($urandom_range(0, 63));
			addr   = (i == 4) ? target : 2'($urandom_range(0, 3));
			send_item(make_write({1'b0, filler, value[i]}, addr, 1'b0));
		end
	endtask

	task automatic run_traffic(input int n);
		int stop_at;
		int pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				load_serial(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b1);
			else if (pick < 80)
				send_item(make_phase(1'($urandom_range(0, 1))));
			else if (pick < 88)
				send_item(make_write(8'($urandom_range(128, 255)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1))));
			else
				send_item(make_write(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1))));
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] board, input logic rev, input logic [5:0] units,
			input logic f32, input logic big);
		wait_idle();
		write_cfg(CFG_BOARD_VARIANT, {3'b000, board});
		write_cfg(CFG_REVISION_1A, {5'b00000, rev});
		write_cfg(CFG_PRG_SIZE_UNITS, units);
		write_cfg(CFG_FIXED_32K_BOARD, {5'b00000, f32});
		write_cfg(CFG_PRG_RAM_OVER_8K, {5'b00000, big});
		cfg_we    <= 1'b0;
		board_sel = board;
		old_rev   = rev;
		rom_units = units;
		force_32k = f32;
		big_ram   = big;
	endtask

	function automatic logic [5:0] units_for(input int k);
		case (k)
			0: return 6'd32;
			1: return 6'd1;
			2: return 6'd0;
			3: return 6'd2;
			4: return 6'd3;
			5: return 6'd16;
			6: return 6'd17;
			7: return 6'd31;
			8: return 6'd63;
			9: return 6'd24;
			10: return 6'd5;
			11: return 6'd15;
			12: return 6'd20;
			13: return 6'd48;
			14: return 6'd8;
			default: return 6'd33;
		endcase
	endfunction

	task automatic reset_dut();
		ctrl_r    = CONTROL_RESET;
		chr_a_r   = '0;
		chr_b_r   = '0;
		prg_r     = '0;
		shift_r   = '0;
		shift_cnt = '0;
		a12_r     = 1'b0;
		board_sel = VAR_STANDARD;
		old_rev   = 1'b0;
		rom_units = SIZE_RESET;
		force_32k = 1'b0;
		big_ram   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_item(make_phase(1'b1));
		// reset write goes through even when back to back
		send_item(make_write(8'hFF, TGT_PRG, 1'b1));
		send_item(make_write(8'h01, TGT_CHR_A, 1'b1));
		load_serial(TGT_CONTROL, 5'h1F, 1'b0);
		load_serial(TGT_CHR_A, 5'h1F, 1'b0);
		load_serial(TGT_CHR_B, 5'h00, 1'b0);
		load_serial(TGT_PRG, 5'h1F, 1'b0);
		send_item(make_phase(1'b1));
		send_item(make_phase(1'b0));
	endtask

	task automatic test_unused_index();
		wait_idle();
		write_cfg(CFG_SPARE_LO, 6'h3F);
		write_cfg(CFG_SPARE_HI, 6'h3F);
		cfg_we <= 1'b0;
		send_item(make_phase(1'b1));
		load_serial(TGT_PRG, 5'h00, 1'b0);
	endtask

	task automatic test_board_sweep(input int k_lo, input int k_hi);
		logic [3:0] k4;
		for (int k = k_lo; k <= k_hi; k++) begin
			k4 = 4'(k);
			set_config(k4[2:0], k4[3] ^ k4[0], units_for(k), (k == 5 || k == 14),
				k4[1] ^ k4[3]);
			run_traffic(48);
		end
	endtask

	task automatic test_random_boards(input int count);
		for (int n = 0; n < count; n++) begin
			set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
				units_for($urandom_range(0, 15)), ($urandom_range(0, 7) == 0),
				1'($urandom_range(0, 1)));
			run_traffic(40);
		end
	endtask

	// hold the result side while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		set_config(VAR_EXT_RAM, 1'b0, 6'd32, 1'b0, 1'b1);
		hold_start <= 1'b1;
		run_traffic(30);
	endtask

	initial begin
		reset_dut();
		test_directed();
		test_unused_index();
		send_idle_pct = 21;
		recv_idle_pct = 49;
		test_board_sweep(0, 7);
		send_idle_pct = 49;
		recv_idle_pct = 21;
		test_board_sweep(8, 15);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_boards(4);
		test_backpressure();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_maps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
